// ===== hdl/chamfer_distance_transform_top_assert.svh =====
// assertion macros for the distance transform block
`ifndef CHAMFER_DISTANCE_TRANSFORM_TOP_ASSERT_SVH
`define CHAMFER_DISTANCE_TRANSFORM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CDT_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CDT_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define CDT_ASSERT_IMP(label, clk, rst, a, c)
`define CDT_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/cdt_pkg.sv =====
`timescale 1ns / 1ps
package cdt_pkg;
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam int DIST_W = 18;
   localparam logic [DIST_W-1:0] DIST_INF = 18'h3FFFF;
   localparam logic [DIST_W-1:0] W_STEP = 18'd256;
   localparam logic [DIST_W-1:0] W_DIAG = 18'd362;
   localparam int OUT_W = 25;
   localparam logic [OUT_W-1:0] OUT_MAX = 25'h1FFFFFF;
   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;
   localparam logic [1:0] CSR_RES  = 2'd2;

   typedef logic [DIST_W-1:0] dist_type;

   // saturated neighbor plus weight, then minimum with current
   function automatic dist_type relax(input dist_type cur, input dist_type nb,
                                      input dist_type w);
      logic [DIST_W:0] s;
      dist_type sv;
      s = {1'b0, nb} + {1'b0, w};
      sv = (s > {1'b0, DIST_INF}) ? DIST_INF : s[DIST_W-1:0];
      return (sv < cur) ? sv : cur;
   endfunction
endpackage

// ===== hdl/chamfer_distance_transform_top.sv =====
`timescale 1ns / 1ps
// Chamfer distance transform. A read transaction steps through a memory read,
// a multiply and a scale. A run sweeps the grid
// forward then backward; each cell needs one memory read per neighbor plus one
// for itself, one write to the memory and one step to the next cell. The
// block is not ready while a transaction works, and a result that waits for
// rsp_ready holds the next run or read in its final step.
// The store holds nothing defined until cells are written; no clearing pass.
`include "chamfer_distance_transform_top_assert.svh"
module chamfer_distance_transform_top
   import cdt_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_col,
   input  logic        req_occupied,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [24:0] rsp_distance_m_q16,
   output logic        rsp_no_obstacle,
   output logic        rsp_out_of_bounds,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = RW + CW;
   localparam logic [10:0] MAXR = 11'(MAX_ROWS);
   localparam logic [10:0] MAXC = 11'(MAX_COLS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD1  = 4'd1;
   localparam logic [3:0] S_RD2  = 4'd2;
   localparam logic [3:0] S_CUR  = 4'd4;
   localparam logic [3:0] S_NB   = 4'd5;
   localparam logic [3:0] S_WR   = 4'd6;
   localparam logic [3:0] S_RSP  = 4'd7;
   localparam logic [3:0] S_NEXT = 4'd8;

   logic [8:0]  rows_ff, cols_ff;
   logic [15:0] res_ff;
   logic [3:0]  state_ff, state_in;
   logic [9:0]  r_ff, r_in, c_ff, c_in, er, ec;
   logic        bwd_ff, bwd_in;
   logic [2:0]  nb_ff;
   dist_type    v_ff, rd_ff;
   logic [1:0]  cmd_ff;
   logic [9:0]  qr_ff, qc_ff;
   logic        occ_ff;
   logic [33:0] prod_ff;
   logic        rv_ff, rk_ff, rno_ff, roob_ff;
   logic [24:0] rd_m_ff;

   dist_type mem [0:(1<<AW)-1];
   logic [AW-1:0] raddr, waddr;
   logic          we;
   dist_type      wdata;

   assign er = ({2'b0, rows_ff} < MAXR) ? {1'b0, rows_ff} : MAXR[9:0];
   assign ec = ({2'b0, cols_ff} < MAXC) ? {1'b0, cols_ff} : MAXC[9:0];

   // neighbor selection for the current pass
   logic [9:0] nr, ncl;
   logic       nok;
   dist_type   nw;
   always_comb begin
      nr = r_ff; ncl = c_ff; nok = 1'b0; nw = W_STEP;
      case (nb_ff)
         3'd0: begin
            nr = bwd_ff ? r_ff + 10'd1 : r_ff - 10'd1;
            nok = bwd_ff ? (r_ff + 10'd1 < er) : (r_ff != 10'd0);
         end
         3'd1: begin
            ncl = bwd_ff ? c_ff + 10'd1 : c_ff - 10'd1;
            nok = bwd_ff ? (c_ff + 10'd1 < ec) : (c_ff != 10'd0);
         end
         3'd2: begin
            nr = bwd_ff ? r_ff + 10'd1 : r_ff - 10'd1;
            ncl = bwd_ff ? c_ff + 10'd1 : c_ff - 10'd1;
            nw = W_DIAG;
            nok = bwd_ff ? (r_ff + 10'd1 < er && c_ff + 10'd1 < ec)
                         : (r_ff != 10'd0 && c_ff != 10'd0);
         end
         3'd3: begin
            nr = bwd_ff ? r_ff + 10'd1 : r_ff - 10'd1;
            ncl = bwd_ff ? c_ff - 10'd1 : c_ff + 10'd1;
            nw = W_DIAG;
            nok = bwd_ff ? (r_ff + 10'd1 < er && c_ff != 10'd0)
                         : (r_ff != 10'd0 && c_ff + 10'd1 < ec);
         end
         default: nok = 1'b0;
      endcase
   end

   logic inb;
   assign inb = ({2'b0, qr_ff} < {2'b0, er}) && ({2'b0, qc_ff} < {2'b0, ec});

   always_comb begin
      state_in = state_ff; r_in = r_ff; c_in = c_ff; bwd_in = bwd_ff;
      raddr = {r_ff[RW-1:0], c_ff[CW-1:0]};
      waddr = {r_ff[RW-1:0], c_ff[CW-1:0]};
      we = 1'b0; wdata = v_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_cmd)
                  CMD_WRITE: state_in = S_WR;
                  CMD_RUN: begin
                     r_in = 10'd0; c_in = 10'd0; bwd_in = 1'b0;
                     state_in = (er == 10'd0 || ec == 10'd0) ? S_RSP : S_CUR;
                  end
                  CMD_READ: state_in = S_RD1;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_WR: begin
            if (cmd_ff == CMD_WRITE) begin
               waddr = {qr_ff[RW-1:0], qc_ff[CW-1:0]};
               we = inb;
               wdata = occ_ff ? '0 : DIST_INF;
               state_in = S_IDLE;
            end else begin
               we = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_RD1: begin
            raddr = {qr_ff[RW-1:0], qc_ff[CW-1:0]};
            state_in = S_RD2;
         end
         S_RD2: state_in = S_RSP;
         S_CUR: state_in = S_NB;
         S_NB: begin
            raddr = {nr[RW-1:0], ncl[CW-1:0]};
            if (nb_ff == 3'd4) state_in = S_WR;
            else state_in = S_NB;
         end
         S_NEXT: begin
            state_in = S_CUR;
            if (!bwd_ff) begin
               if (c_ff + 10'd1 < ec) c_in = c_ff + 10'd1;
               else if (r_ff + 10'd1 < er) begin
                  c_in = 10'd0; r_in = r_ff + 10'd1;
               end else bwd_in = 1'b1;
            end else begin
               if (c_ff != 10'd0) c_in = c_ff - 10'd1;
               else if (r_ff != 10'd0) begin
                  c_in = ec - 10'd1; r_in = r_ff - 10'd1;
               end else state_in = S_RSP;
            end
         end
         S_RSP: if (!rv_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // neighbor relaxation pipeline: issue read k, fold result of read k-1
   logic       fold_ff;
   dist_type   fw_ff;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   dist_type v_fold;
   always_comb begin
      v_fold = v_ff;
      if (state_ff == S_NB && nb_ff == 3'd0) v_fold = rd_ff;
      else if (fold_ff) v_fold = relax(v_ff, rd_ff, fw_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= 9'd256; cols_ff <= 9'd256; res_ff <= 16'd3277;
         rv_ff <= 1'b0; fold_ff <= 1'b0;
         bwd_ff <= 1'b0; nb_ff <= 3'd0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROWS: rows_ff <= csr_write_data[8:0];
               CSR_COLS: cols_ff <= csr_write_data[8:0];
               CSR_RES:  res_ff <= csr_write_data;
               default: ;
            endcase
         end
         state_ff <= state_in;
         bwd_ff <= bwd_in;
         if (state_ff == S_CUR) nb_ff <= 3'd0;
         else if (state_ff == S_NB) nb_ff <= nb_ff + 3'd1;
         fold_ff <= (state_ff == S_NB) && nok && (nb_ff != 3'd4);
         if (state_ff == S_RSP && (!rv_ff || rsp_ready)) rv_ff <= 1'b1;
         else if (rsp_valid && rsp_ready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; c_ff <= c_in;
      fw_ff <= nw;
      if (state_ff == S_NB) v_ff <= v_fold;
      else if (state_ff == S_RD2) v_ff <= rd_ff;
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         cmd_ff <= req_cmd; qr_ff <= {2'b0, req_row}; qc_ff <= {2'b0, req_col};
         occ_ff <= req_occupied;
      end
      if (state_ff == S_RD2) prod_ff <= 34'(rd_ff) * 34'(res_ff) + 34'd128;
      if (state_ff == S_RSP && (!rv_ff || rsp_ready)) begin
         rk_ff <= (cmd_ff == CMD_READ);
         rd_m_ff <= '0; rno_ff <= 1'b0; roob_ff <= 1'b0;
         if (cmd_ff == CMD_READ) begin
            if (!inb) roob_ff <= 1'b1;
            else if (v_ff == DIST_INF) rno_ff <= 1'b1;
            else rd_m_ff <= (prod_ff[33:8] > {1'b0, OUT_MAX}) ? OUT_MAX : prod_ff[32:8];
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_kind = rk_ff;
   assign rsp_distance_m_q16 = rd_m_ff;
   assign rsp_no_obstacle = rno_ff;
   assign rsp_out_of_bounds = roob_ff;

   `CDT_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_ready)
   `CDT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CDT_ASSERT_IMP(a_read_flags, clock, reset, rsp_valid, !(rsp_no_obstacle && rsp_out_of_bounds))
endmodule

// ===== dv/chamfer_distance_transform_top_tb.sv =====
`timescale 1ns / 1ps
module chamfer_distance_transform_top_tb;
   import cdt_pkg::*;

   localparam int GRID_DIM = 256;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] row;
      logic [7:0] col;
      logic       occupied;
   } cell_op_type;

   typedef struct {
      logic        kind;
      logic [24:0] distance;
      logic        no_obstacle;
      logic        out_of_bounds;
   } distance_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_WRITE;
   logic [7:0]  req_row = 8'd0;
   logic [7:0]  req_col = 8'd0;
   logic        req_occupied = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [24:0] rsp_distance_m_q16;
   logic        rsp_no_obstacle;
   logic        rsp_out_of_bounds;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_ROWS;
   logic [15:0] csr_write_data = 16'd0;

   chamfer_distance_transform_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cell_op_type      op_queue[$];
   distance_rsp_type distance_due[$];
   cell_op_type      op_now;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               fail_count = 0;
   int               op_count = 0;

   // predictor state
   dist_type    cell_mem [GRID_DIM*GRID_DIM];
   logic [8:0]  rows_cfg = 9'd256;
   logic [8:0]  cols_cfg = 9'd256;
   logic [15:0] res_cfg = 16'd3277;

   initial begin
      for (int i = 0; i < GRID_DIM*GRID_DIM; i++) begin
         cell_mem[i] = '0;
      end
   end

   function automatic int used_rows();
      return (rows_cfg < GRID_DIM) ? int'(rows_cfg) : GRID_DIM;
   endfunction

   function automatic int used_cols();
      return (cols_cfg < GRID_DIM) ? int'(cols_cfg) : GRID_DIM;
   endfunction

   function automatic dist_type min_via(dist_type cur, dist_type nb, dist_type w);
      logic [DIST_W:0] s;
      s = {1'b0, nb} + {1'b0, w};
      if (s > {1'b0, DIST_INF}) s = {1'b0, DIST_INF};
      return (s[DIST_W-1:0] < cur) ? s[DIST_W-1:0] : cur;
   endfunction

   task automatic chamfer_sweep();
      int nr, nc;
      dist_type v;
      nr = used_rows();
      nc = used_cols();
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            v = cell_mem[r*GRID_DIM+c];
            if (r > 0) v = min_via(v, cell_mem[(r-1)*GRID_DIM+c], W_STEP);
            if (c > 0) v = min_via(v, cell_mem[r*GRID_DIM+c-1], W_STEP);
            if (r > 0 && c > 0) v = min_via(v, cell_mem[(r-1)*GRID_DIM+c-1], W_DIAG);
            if (r > 0 && c + 1 < nc) v = min_via(v, cell_mem[(r-1)*GRID_DIM+c+1], W_DIAG);
            cell_mem[r*GRID_DIM+c] = v;
         end
      end
      for (int r = nr - 1; r >= 0; r--) begin
         for (int c = nc - 1; c >= 0; c--) begin
            v = cell_mem[r*GRID_DIM+c];
            if (r + 1 < nr) v = min_via(v, cell_mem[(r+1)*GRID_DIM+c], W_STEP);
            if (c + 1 < nc) v = min_via(v, cell_mem[r*GRID_DIM+c+1], W_STEP);
            if (r + 1 < nr && c + 1 < nc)
               v = min_via(v, cell_mem[(r+1)*GRID_DIM+c+1], W_DIAG);
            if (r + 1 < nr && c > 0)
               v = min_via(v, cell_mem[(r+1)*GRID_DIM+c-1], W_DIAG);
            cell_mem[r*GRID_DIM+c] = v;
         end
      end
   endtask

   task automatic predict_response(cell_op_type op);
      distance_rsp_type rsp;
      bit inb;
      dist_type d;
      logic [63:0] p;
      inb = (int'(op.row) < used_rows()) && (int'(op.col) < used_cols());
      rsp = '{1'b0, 25'd0, 1'b0, 1'b0};
      case (op.cmd)
         CMD_WRITE: begin
            if (inb) cell_mem[op.row*GRID_DIM+op.col] = op.occupied ? '0 : DIST_INF;
         end
         CMD_RUN: begin
            chamfer_sweep();
            distance_due.push_back(rsp);
         end
         CMD_READ: begin
            rsp.kind = 1'b1;
            if (!inb) begin
               rsp.out_of_bounds = 1'b1;
            end else begin
               d = cell_mem[op.row*GRID_DIM+op.col];
               if (d >= DIST_INF) begin
                  rsp.no_obstacle = 1'b1;
               end else begin
                  p = (64'(d) * 64'(res_cfg) + 64'd128) >> 8;
                  if (p > 64'(OUT_MAX)) p = 64'(OUT_MAX);
                  rsp.distance = p[24:0];
               end
            end
            distance_due.push_back(rsp);
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_response(op_now);
         if (!req_valid || req_ready) begin
            if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               op_now = op_queue.pop_front();
               req_cmd <= op_now.cmd;
               req_row <= op_now.row;
               req_col <= op_now.col;
               req_occupied <= op_now.occupied;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      distance_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (distance_due.size() == 0) begin
               $error("unexpected result transaction");
               fail_count++;
            end else begin
               want = distance_due.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d actual %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_distance_m_q16 !== want.distance) begin
                  $error("distance_m_q16: expected %0d actual %0d",
                         want.distance, rsp_distance_m_q16);
                  fail_count++;
               end
               if (rsp_no_obstacle !== want.no_obstacle) begin
                  $error("no_obstacle: expected %0d actual %0d",
                         want.no_obstacle, rsp_no_obstacle);
                  fail_count++;
               end
               if (rsp_out_of_bounds !== want.out_of_bounds) begin
                  $error("out_of_bounds: expected %0d actual %0d",
                         want.out_of_bounds, rsp_out_of_bounds);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic add_op(logic [1:0] cmd, logic [7:0] r, logic [7:0] c, logic o);
      op_queue.push_back('{cmd, r, c, o});
      op_count++;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (op_queue.size() > 0 || req_valid || distance_due.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(logic [8:0] r, logic [8:0] c, logic [15:0] res);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_write_data <= {7'd0, r};
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_write_data <= {7'd0, c};
      @(posedge clock);
      csr_index <= CSR_RES;
      csr_write_data <= res;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      rows_cfg = r;
      cols_cfg = c;
      res_cfg = res;
   endtask

   task automatic add_noise();
      int nr, nc;
      nr = used_rows();
      nc = used_cols();
      if ($urandom_range(1) == 0) begin
         add_op(2'd3, 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (nr < GRID_DIM) begin
         add_op(CMD_WRITE, 8'($urandom_range(GRID_DIM-1, nr)), 8'($urandom), 1'($urandom));
      end else if (nc < GRID_DIM) begin
         add_op(CMD_WRITE, 8'($urandom), 8'($urandom_range(GRID_DIM-1, nc)), 1'($urandom));
      end
   endtask

   task automatic add_reads(int n);
      int nr, nc;
      nr = used_rows();
      nc = used_cols();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(4) == 0 && nr < GRID_DIM)
            add_op(CMD_READ, 8'($urandom_range(GRID_DIM-1, nr)), 8'($urandom), 1'($urandom));
         else if ($urandom_range(4) == 0 && nc < GRID_DIM)
            add_op(CMD_READ, 8'($urandom), 8'($urandom_range(GRID_DIM-1, nc)), 1'($urandom));
         else
            add_op(CMD_READ, 8'($urandom_range(nr-1)), 8'($urandom_range(nc-1)),
                   1'($urandom));
      end
   endtask

   initial begin
      int pick, density, nr, nc, phase;
      logic [8:0] r9, c9;
      logic [15:0] res;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners of the full default grid, no run since most cells are unwritten
      add_op(CMD_WRITE, 8'd0, 8'd0, 1'b1);
      add_op(CMD_WRITE, 8'd255, 8'd255, 1'b0);
      add_op(CMD_WRITE, 8'd255, 8'd0, 1'b1);
      add_op(CMD_WRITE, 8'd0, 8'd255, 1'b0);
      add_op(2'd3, 8'd255, 8'd255, 1'b1);
      add_op(CMD_READ, 8'd0, 8'd0, 1'b0);
      add_op(CMD_READ, 8'd255, 8'd255, 1'b1);
      add_op(CMD_READ, 8'd255, 8'd0, 1'b0);
      add_op(CMD_READ, 8'd0, 8'd255, 1'b0);
      drain();

      // empty grid
      set_grid(9'd0, 9'd0, 16'd65535);
      add_op(CMD_WRITE, 8'd0, 8'd0, 1'b0);
      add_op(CMD_RUN, 8'd0, 8'd0, 1'b0);
      add_op(CMD_READ, 8'd0, 8'd0, 1'b0);
      add_op(CMD_READ, 8'd255, 8'd255, 1'b0);
      drain();

      // counts above the array size clamp
      set_grid(9'd511, 9'd300, 16'd1);
      add_op(CMD_READ, 8'd255, 8'd255, 1'b0);
      add_op(CMD_READ, 8'd0, 8'd0, 1'b0);
      drain();

      // single row across all columns, obstacle at one end
      set_grid(9'd1, 9'd256, 16'd65535);
      for (int c = 0; c < GRID_DIM; c++) add_op(CMD_WRITE, 8'd0, 8'(c), c == 0);
      add_op(CMD_RUN, 8'd0, 8'd0, 1'b0);
      add_op(CMD_READ, 8'd0, 8'd255, 1'b0);
      add_op(CMD_READ, 8'd0, 8'd1, 1'b0);
      add_op(CMD_READ, 8'd1, 8'd0, 1'b0);
      drain();

      phase = 0;
      while (op_count < 1850) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         pick = $urandom_range(9);
         if (pick == 0) begin
            r9 = 9'($urandom_range(511, 256));
            c9 = 9'($urandom_range(2, 1));
         end else if (pick == 1) begin
            r9 = 9'($urandom_range(2, 1));
            c9 = 9'($urandom_range(511, 256));
         end else begin
            r9 = 9'($urandom_range(12, 1));
            c9 = 9'($urandom_range(12, 1));
         end
         case ($urandom_range(5))
            0: res = 16'd1;
            1: res = 16'd65535;
            2: res = 16'd0;
            default: res = 16'($urandom_range(65535, 1));
         endcase
         set_grid(r9, c9, res);
         nr = used_rows();
         nc = used_cols();
         case ($urandom_range(3))
            0: density = 0;
            1: density = 3;
            2: density = 20;
            default: density = 60;
         endcase
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
               add_op(CMD_WRITE, 8'(r), 8'(c), $urandom_range(99) < density);
               if ($urandom_range(19) == 0) add_noise();
            end
         end
         add_op(CMD_RUN, 8'($urandom), 8'($urandom), 1'($urandom));
         add_reads($urandom_range(25, 10));
         // patch a few cells on top of the distances and run again
         for (int i = 0; i < $urandom_range(4); i++)
            add_op(CMD_WRITE, 8'($urandom_range(nr-1)), 8'($urandom_range(nc-1)),
                   1'($urandom));
         add_op(CMD_RUN, 8'd0, 8'd0, 1'b0);
         add_reads($urandom_range(15, 5));
         add_noise();
         drain();
         phase++;
      end

      send_idle_pct = 0;
      stall_pct = 0;
      drain();
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cdt_pkg.sv
hdl/chamfer_distance_transform_top.sv
dv/chamfer_distance_transform_top_tb.sv
